/* rtl/assert_macros.svh */
// Assertion macros for the checker ntrbseg_chk.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, sampled on clk, off while rst_n is low.
`define CHK_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("ntrbseg check failed");

// Same-cycle implication.
`define CHK_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ntrbseg check failed");

`endif

/* rtl/ntrbseg_pkg.sv */
// Types, constants and field layout for the Normal TRB segmenter.
// No dependencies.
package ntrbseg_pkg;

    localparam int PAGE_BYTES_DEF = 4096;

    localparam int ADDR_W  = 64;
    localparam int LEN_W   = 16;
    localparam int MPS_W   = 11;
    localparam int EP_W    = 5;
    localparam int SLOT_W  = 8;
    localparam int WORD_W  = 32;

    localparam int IN_TDATA_W  = 112;
    localparam int OUT_TDATA_W = 144;

    // ceil divide: numerator is length + packet size - 1
    localparam int DIV_BITS   = LEN_W + 1;
    localparam int DIV_STEP_W = $clog2(DIV_BITS);
    localparam int PKT_KEEP_W = 15;

    localparam logic FLAVOR_RESET = 1'b1;
    localparam logic FLAVOR_BULK  = 1'b1;

    localparam logic KIND_TRB      = 1'b0;
    localparam logic KIND_DOORBELL = 1'b1;

    localparam logic [WORD_W-1:0] CTRL_TYPE_NORMAL = 32'h0000_0400;
    localparam logic [WORD_W-1:0] CTRL_CHAIN       = 32'h0000_0010;
    localparam logic [WORD_W-1:0] CTRL_LAST        = 32'h0000_0020;
    localparam logic [WORD_W-1:0] CTRL_DIR_IN      = 32'h0000_0040;
    localparam logic [WORD_W-1:0] CTRL_BIT1        = 32'h0000_0002;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHUNK,
        ST_DIV,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic               start;
        logic [DIV_BITS-1:0] numer;
        logic [MPS_W-1:0]    divisor;
    } div_req_t;

    typedef struct packed {
        logic               done;
        logic [LEN_W-1:0]   quotient;
    } div_stat_t;

    function automatic logic [WORD_W-1:0] ctrl_word(input logic flavor,
                                                     input logic last,
                                                     input logic dir_in);
        logic [WORD_W-1:0] w;
        w = CTRL_TYPE_NORMAL;
        if (flavor == FLAVOR_BULK)
        begin
            if (!last)
                w = w | CTRL_CHAIN;
            if (dir_in)
                w = w | CTRL_DIR_IN;
        end
        else
        begin
            w = w | CTRL_DIR_IN | CTRL_BIT1;
        end
        if (last)
            w = w | CTRL_LAST;
        return w;
    endfunction

endpackage

/* rtl/xhci_normal_trb_segmenter_top.sv */
// Top level of the Normal TRB segmenter: chunk sequencer and output register.
// Depends on ntrbseg_pkg and ntrbseg_div.
//
// Usage:
//   s_axis carries one transfer request per beat; m_axis returns one Normal
//   TRB per page chunk (tuser 0) and then one doorbell item (tuser 1, tlast 1).
//   A zero-length request returns only the doorbell item.
//   cfg_we/cfg_wdata write the flavor bit (1 bulk flags, 0 normal flags);
//   write it only while no request is in flight.
// Sequence:
//   Each TRB passes through a setup state, the bit-serial divider (packets
//   left = ceil(bytes left / packet size)) and a load of the output register,
//   then waits for m_axis_tready. s_axis_tready is high only between
//   requests.
// Reset:
//   rst_n clears the sequencer to idle and sets flavor to bulk.
//   A stalled receiver holds the current item in the output register.
module xhci_normal_trb_segmenter_top
#(
    parameter int PAGE_BYTES = ntrbseg_pkg::PAGE_BYTES_DEF
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic                                 cfg_wdata,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // buffer_address, data_length, max_packet_size, endpoint_number,
    // doorbell_target, endpoint_in, slot_number, zero pad
    input  logic [ntrbseg_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // slot_out, endpoint_out, trb_address, status_word, control_word, zero pad
    output logic [ntrbseg_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    // result_kind
    output logic                                 m_axis_tuser,
    // final_res
    output logic                                 m_axis_tlast
);

    localparam int PAGE_W = $clog2(PAGE_BYTES);
    localparam int CNT_W  = PAGE_W + 1;
    localparam int EXT_W  = ntrbseg_pkg::LEN_W + 1;

    ntrbseg_pkg::state_t                    state_reg, state_next;
    logic                                   flavor_reg;

    logic [ntrbseg_pkg::ADDR_W-1:0]         addr_reg, addr_next;
    logic [ntrbseg_pkg::LEN_W-1:0]          left_reg, left_next;
    logic [ntrbseg_pkg::MPS_W-1:0]          mps_reg, mps_next;
    logic [ntrbseg_pkg::EP_W-1:0]           ep_reg, ep_next;
    logic [ntrbseg_pkg::EP_W-1:0]           dbt_reg, dbt_next;
    logic                                   dir_reg, dir_next;
    logic [ntrbseg_pkg::SLOT_W-1:0]         slot_reg, slot_next;

    logic                                   out_kind_reg, out_kind_next;
    logic                                   out_last_reg, out_last_next;
    logic [ntrbseg_pkg::EP_W-1:0]           out_ep_reg, out_ep_next;
    logic [ntrbseg_pkg::ADDR_W-1:0]         out_addr_reg, out_addr_next;
    logic [ntrbseg_pkg::WORD_W-1:0]         out_status_reg, out_status_next;
    logic [ntrbseg_pkg::WORD_W-1:0]         out_ctrl_reg, out_ctrl_next;

    logic [ntrbseg_pkg::ADDR_W-1:0]         in_addr;
    logic [ntrbseg_pkg::LEN_W-1:0]          in_len;
    logic [ntrbseg_pkg::MPS_W-1:0]          in_mps;
    logic [ntrbseg_pkg::EP_W-1:0]           in_ep;
    logic [ntrbseg_pkg::EP_W-1:0]           in_dbt;
    logic                                   in_dir;
    logic [ntrbseg_pkg::SLOT_W-1:0]         in_slot;

    logic [CNT_W-1:0]                       room;
    logic [EXT_W-1:0]                       room_ext;
    logic                                   is_last;
    logic [ntrbseg_pkg::LEN_W-1:0]          chunk;
    logic                                   in_fire;
    logic                                   out_fire;
    logic                                   div_start;

    ntrbseg_pkg::div_req_t                  div_req;
    ntrbseg_pkg::div_stat_t                 div_stat;

    assign in_addr = s_axis_tdata[63:0];
    assign in_len  = s_axis_tdata[79:64];
    assign in_mps  = s_axis_tdata[90:80];
    assign in_ep   = s_axis_tdata[95:91];
    assign in_dbt  = s_axis_tdata[100:96];
    assign in_dir  = s_axis_tdata[101];
    assign in_slot = s_axis_tdata[109:102];

    assign s_axis_tready = (state_reg == ntrbseg_pkg::ST_IDLE);
    assign m_axis_tvalid = (state_reg == ntrbseg_pkg::ST_OUT);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_fire      = m_axis_tvalid && m_axis_tready;

    // bytes to the next page boundary
    assign room     = CNT_W'(PAGE_BYTES) - {1'b0, addr_reg[PAGE_W-1:0]};
    assign room_ext = EXT_W'(room);
    assign is_last  = room_ext >= {1'b0, left_reg};
    assign chunk    = is_last ? left_reg : room_ext[ntrbseg_pkg::LEN_W-1:0];

    assign div_req.start   = div_start;
    assign div_req.numer   = EXT_W'(left_reg) + EXT_W'(mps_reg) - EXT_W'(1);
    assign div_req.divisor = mps_reg;

    ntrbseg_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .stat  (div_stat)
    );

    always_comb
    begin
        state_next      = state_reg;
        div_start       = 1'b0;
        addr_next       = addr_reg;
        left_next       = left_reg;
        mps_next        = mps_reg;
        ep_next         = ep_reg;
        dbt_next        = dbt_reg;
        dir_next        = dir_reg;
        slot_next       = slot_reg;
        out_kind_next   = out_kind_reg;
        out_last_next   = out_last_reg;
        out_ep_next     = out_ep_reg;
        out_addr_next   = out_addr_reg;
        out_status_next = out_status_reg;
        out_ctrl_next   = out_ctrl_reg;

        case (state_reg)
            ntrbseg_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    addr_next  = in_addr;
                    left_next  = in_len;
                    mps_next   = (in_mps == '0) ? ntrbseg_pkg::MPS_W'(1) : in_mps;
                    ep_next    = in_ep;
                    dbt_next   = in_dbt;
                    dir_next   = in_dir;
                    slot_next  = in_slot;
                    state_next = ntrbseg_pkg::ST_CHUNK;
                end
            end
            ntrbseg_pkg::ST_CHUNK:
            begin
                if (left_reg == '0)
                begin
                    out_kind_next   = ntrbseg_pkg::KIND_DOORBELL;
                    out_last_next   = 1'b1;
                    out_ep_next     = dbt_reg;
                    out_addr_next   = '0;
                    out_status_next = '0;
                    out_ctrl_next   = '0;
                    state_next      = ntrbseg_pkg::ST_OUT;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = ntrbseg_pkg::ST_DIV;
                end
            end
            ntrbseg_pkg::ST_DIV:
            begin
                if (div_stat.done)
                begin
                    out_kind_next   = ntrbseg_pkg::KIND_TRB;
                    out_last_next   = 1'b0;
                    out_ep_next     = ep_reg;
                    out_addr_next   = addr_reg;
                    out_status_next = {div_stat.quotient[ntrbseg_pkg::PKT_KEEP_W-1:0],
                                       1'b0, chunk};
                    out_ctrl_next   = ntrbseg_pkg::ctrl_word(flavor_reg, is_last, dir_reg);
                    state_next      = ntrbseg_pkg::ST_OUT;
                end
            end
            ntrbseg_pkg::ST_OUT:
            begin
                if (out_fire)
                begin
                    if (out_last_reg)
                    begin
                        state_next = ntrbseg_pkg::ST_IDLE;
                    end
                    else
                    begin
                        addr_next  = addr_reg + ntrbseg_pkg::ADDR_W'(chunk);
                        left_next  = left_reg - chunk;
                        state_next = ntrbseg_pkg::ST_CHUNK;
                    end
                end
            end
            default:
            begin
                state_next = ntrbseg_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ntrbseg_pkg::ST_IDLE;
            flavor_reg <= ntrbseg_pkg::FLAVOR_RESET;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
                flavor_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg       <= addr_next;
        left_reg       <= left_next;
        mps_reg        <= mps_next;
        ep_reg         <= ep_next;
        dbt_reg        <= dbt_next;
        dir_reg        <= dir_next;
        slot_reg       <= slot_next;
        out_kind_reg   <= out_kind_next;
        out_last_reg   <= out_last_next;
        out_ep_reg     <= out_ep_next;
        out_addr_reg   <= out_addr_next;
        out_status_reg <= out_status_next;
        out_ctrl_reg   <= out_ctrl_next;
    end

    assign m_axis_tdata = {3'b000, out_ctrl_reg, out_status_reg, out_addr_reg,
                           out_ep_reg, slot_reg};
    assign m_axis_tuser = out_kind_reg;
    assign m_axis_tlast = out_last_reg;

endmodule

/* rtl/ntrbseg_div.sv */
// Restoring divider, one quotient bit per cycle.
// Depends on ntrbseg_pkg.
module ntrbseg_div
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  ntrbseg_pkg::div_req_t  req,
    output ntrbseg_pkg::div_stat_t stat
);

    logic                                  busy_reg, busy_next;
    logic                                  done_reg, done_next;
    logic [ntrbseg_pkg::DIV_STEP_W-1:0]    step_reg, step_next;
    logic [ntrbseg_pkg::MPS_W-1:0]         rem_reg, rem_next;
    logic [ntrbseg_pkg::DIV_BITS-1:0]      quo_reg, quo_next;
    logic [ntrbseg_pkg::MPS_W-1:0]         dvs_reg, dvs_next;
    logic [ntrbseg_pkg::MPS_W:0]           rem_shift;
    logic [ntrbseg_pkg::MPS_W:0]           diff;
    logic                                  fits;

    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[ntrbseg_pkg::DIV_BITS-1]};
        diff      = rem_shift - {1'b0, dvs_reg};
        fits      = rem_shift >= {1'b0, dvs_reg};

        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;

        if (req.start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            rem_next  = '0;
            quo_next  = req.numer;
            dvs_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            rem_next  = fits ? diff[ntrbseg_pkg::MPS_W-1:0]
                             : rem_shift[ntrbseg_pkg::MPS_W-1:0];
            quo_next  = {quo_reg[ntrbseg_pkg::DIV_BITS-2:0], fits};
            step_next = step_reg + 1'b1;
            if (step_reg == ntrbseg_pkg::DIV_STEP_W'(ntrbseg_pkg::DIV_BITS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign stat.done     = done_reg;
    assign stat.quotient = quo_reg[ntrbseg_pkg::LEN_W-1:0];

endmodule

/* rtl/ntrbseg_chk.sv */
// Port-level checker for the Normal TRB segmenter, bound to the top level.
// Depends on assert_macros.svh and ntrbseg_pkg.
`include "assert_macros.svh"

module ntrbseg_chk
(
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 s_axis_tvalid,
    input logic                                 s_axis_tready,
    input logic                                 m_axis_tvalid,
    input logic                                 m_axis_tready,
    input logic [ntrbseg_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    input logic                                 m_axis_tuser,
    input logic                                 m_axis_tlast
);

    logic in_fire;
    logic out_fire;

    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign out_fire = m_axis_tvalid && m_axis_tready;

    // stalled output request holds its data
    `CHK_ASSERT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))

    // no new request taken while a result is pending
    `CHK_IMPLIES(a_no_overlap, clk, rst_n, s_axis_tready, !m_axis_tvalid)

    // a taken request closes the input
    `CHK_ASSERT(a_busy_after_accept, clk, rst_n, in_fire |=> !s_axis_tready)

    // only the doorbell ends a run, and it is always the last item
    `CHK_IMPLIES(a_doorbell_last, clk, rst_n, m_axis_tvalid, m_axis_tuser == m_axis_tlast)

    // after the doorbell the block is idle again
    `CHK_ASSERT(a_idle_after_db, clk, rst_n, out_fire && m_axis_tlast |=> s_axis_tready)

endmodule

bind xhci_normal_trb_segmenter_top ntrbseg_chk u_ntrbseg_chk
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

/* bench/xhci_normal_trb_segmenter_top_tb.sv */
`timescale 1ns / 100ps
// Self-checking bench for xhci_normal_trb_segmenter_top: page-split TRBs and doorbell items.
// Depends on ntrbseg_pkg and the segmenter RTL; predicts each request's items in-bench.
module xhci_normal_trb_segmenter_top_tb;
    import ntrbseg_pkg::*;

    localparam int PAGE = PAGE_BYTES_DEF;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int SETTLE_CYCLES = 40;

    typedef struct {
        logic [ADDR_W-1:0] buffer_address;
        logic [LEN_W-1:0]  data_length;
        logic [MPS_W-1:0]  max_packet_size;
        logic [EP_W-1:0]   endpoint_number;
        logic [EP_W-1:0]   doorbell_target;
        logic              endpoint_in;
        logic [SLOT_W-1:0] slot_number;
    } xfer_req_t;

    typedef struct {
        logic              kind;
        logic [SLOT_W-1:0] slot;
        logic [EP_W-1:0]   ep;
        logic [ADDR_W-1:0] addr;
        logic [WORD_W-1:0] status;
        logic [WORD_W-1:0] ctrl;
        logic              fin;
    } trb_item_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic cfg_wdata = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [IN_TDATA_W-1:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic m_axis_tuser;
    logic m_axis_tlast;

    trb_item_t pending_items[$];
    trb_item_t exp_item;
    logic flavor_shadow = FLAVOR_RESET;
    int tx_idle_pct = 29;
    int rx_idle_pct = 82;
    int mismatch_count = 0;
    int requests_sent = 0;
    int trbs_checked = 0;
    int doorbells_checked = 0;
    int idle_cycles = 0;

    xhci_normal_trb_segmenter_top DUT (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast)
    );

    always #5 clk = ~clk;

    always @(negedge clk)
    begin
        m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // page split, packets-left count and flags for one request
    task automatic build_expected_items(input xfer_req_t r);
        longint unsigned pos;
        longint unsigned left;
        longint unsigned cnt;
        longint unsigned packets;
        longint unsigned mps;
        logic [63:0] wide;
        logic [ADDR_W-1:0] addr;
        logic last;
        trb_item_t it;
        pos = 0;
        mps = (r.max_packet_size == 0) ? 1 : r.max_packet_size;
        while (pos < r.data_length)
        begin
            addr = r.buffer_address + pos;
            left = r.data_length - pos;
            cnt = PAGE - (addr % PAGE);
            last = (cnt >= left);
            if (last)
                cnt = left;
            packets = (left + mps - 1) / mps;
            wide = ((packets & 64'hFFFF) << 17) | (cnt & 64'hFFFF);
            it.kind = KIND_TRB;
            it.slot = r.slot_number;
            it.ep = r.endpoint_number;
            it.addr = addr;
            it.status = wide[31:0];
            it.ctrl = CTRL_TYPE_NORMAL;
            if (flavor_shadow == FLAVOR_BULK)
            begin
                if (!last)
                    it.ctrl = it.ctrl | CTRL_CHAIN;
                if (r.endpoint_in)
                    it.ctrl = it.ctrl | CTRL_DIR_IN;
            end
            else
            begin
                it.ctrl = it.ctrl | CTRL_DIR_IN | CTRL_BIT1;
            end
            if (last)
                it.ctrl = it.ctrl | CTRL_LAST;
            it.fin = 1'b0;
            pending_items.push_back(it);
            pos = pos + cnt;
        end
        it.kind = KIND_DOORBELL;
        it.slot = r.slot_number;
        it.ep = r.doorbell_target;
        it.addr = '0;
        it.status = '0;
        it.ctrl = '0;
        it.fin = 1'b1;
        pending_items.push_back(it);
    endtask

    function automatic void check_field(input string name, input logic [63:0] e,
                                        input logic [63:0] a);
        if (e !== a)
        begin
            $error("%s: expected %0h, got %0h", name, e, a);
            mismatch_count++;
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (m_axis_tuser === KIND_DOORBELL)
                doorbells_checked++;
            else
                trbs_checked++;
            if (pending_items.size() == 0)
            begin
                $error("unexpected result: tdata %0h", m_axis_tdata);
                mismatch_count++;
            end
            else
            begin
                exp_item = pending_items.pop_front();
                check_field("result_kind", exp_item.kind, m_axis_tuser);
                check_field("slot_out", exp_item.slot, m_axis_tdata[7:0]);
                check_field("endpoint_out", exp_item.ep, m_axis_tdata[12:8]);
                check_field("trb_address", exp_item.addr, m_axis_tdata[76:13]);
                check_field("status_word", exp_item.status, m_axis_tdata[108:77]);
                check_field("control_word", exp_item.ctrl, m_axis_tdata[140:109]);
                check_field("final_res", exp_item.fin, m_axis_tlast);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles = 0;
        else
            idle_cycles = idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // entered and left at a falling edge; tvalid stays high for a back-to-back request
    task automatic send_request(input logic [ADDR_W-1:0] addr, input logic [LEN_W-1:0] len,
                                input logic [MPS_W-1:0] mps, input logic [EP_W-1:0] ep,
                                input logic [EP_W-1:0] dbt, input logic dir_in,
                                input logic [SLOT_W-1:0] slot);
        xfer_req_t r;
        int gap;
        r.buffer_address = addr;
        r.data_length = len;
        r.max_packet_size = mps;
        r.endpoint_number = ep;
        r.doorbell_target = dbt;
        r.endpoint_in = dir_in;
        r.slot_number = slot;
        gap = 0;
        while ($urandom_range(99) < tx_idle_pct)
            gap++;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {2'b00, slot, dir_in, dbt, ep, mps, len, addr};
        do
            @(posedge clk);
        while (!s_axis_tready);
        build_expected_items(r);
        requests_sent++;
        @(negedge clk);
    endtask

    task automatic drain;
        s_axis_tvalid <= 1'b0;
        while (pending_items.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_flavor(input logic value);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        flavor_shadow = value;
    endtask

    task automatic test_zero_length;
        send_request(64'h0, 16'd0, 11'd64, 5'd0, 5'd0, 1'b0, 8'd0);
        send_request({64{1'b1}}, 16'd0, 11'd2047, 5'd31, 5'd31, 1'b1, 8'd255);
        drain();
    endtask

    task automatic test_page_split;
        send_request(64'h1000, 16'd1, 11'd512, 5'd1, 5'd2, 1'b1, 8'd3);
        send_request(64'h2000, 16'd4096, 11'd512, 5'd4, 5'd5, 1'b0, 8'd6);
        send_request(64'h3000, 16'd4097, 11'd512, 5'd7, 5'd8, 1'b1, 8'd9);
        send_request(64'h4FFF, 16'd2, 11'd1, 5'd10, 5'd11, 1'b0, 8'd12);
        send_request(64'h1234_5678_9ABC_DFFF, 16'hFFFF, 11'd1024, 5'd31, 5'd0, 1'b1, 8'd128);
        drain();
    endtask

    task automatic test_packet_size_extremes;
        send_request(64'h8000, 16'd3000, 11'd0, 5'd13, 5'd14, 1'b1, 8'd15);
        send_request(64'h0, 16'hFFFF, 11'd1, 5'd16, 5'd17, 1'b0, 8'd18);
        send_request(64'h9100, 16'd5000, 11'd1023, 5'd19, 5'd20, 1'b1, 8'd21);
        send_request(64'hA000, 16'd9000, 11'd1025, 5'd22, 5'd23, 1'b0, 8'd24);
        send_request(64'hB800, 16'd7000, 11'd2047, 5'd25, 5'd26, 1'b1, 8'd25);
        drain();
    endtask

    task automatic test_address_wrap;
        send_request(64'hFFFF_FFFF_FFFF_F800, 16'd4096, 11'd64, 5'd2, 5'd3, 1'b1, 8'd44);
        send_request(64'hFFFF_FFFF_FFFF_FFFF, 16'd300, 11'd8, 5'd30, 5'd1, 1'b0, 8'd77);
        drain();
    endtask

    task automatic test_flavor_flags;
        write_flavor(1'b0);
        send_request(64'h5F00, 16'd600, 11'd64, 5'd6, 5'd7, 1'b1, 8'd1);
        send_request(64'h7FF0, 16'd8200, 11'd512, 5'd8, 5'd9, 1'b0, 8'd2);
        send_request(64'h0, 16'd0, 11'd64, 5'd3, 5'd4, 1'b1, 8'd200);
        drain();
        write_flavor(1'b1);
        send_request(64'h5F00, 16'd600, 11'd64, 5'd6, 5'd7, 1'b0, 8'd1);
        send_request(64'h7FF0, 16'd8200, 11'd512, 5'd8, 5'd9, 1'b1, 8'd2);
        drain();
    endtask

    task automatic random_request;
        logic [ADDR_W-1:0] addr;
        logic [LEN_W-1:0] len;
        logic [MPS_W-1:0] mps;
        addr = {$urandom, $urandom};
        case ($urandom_range(3))
            0: addr[11:0] = 12'(PAGE - $urandom_range(1, 64));
            1: addr = 64'hFFFF_FFFF_FFFF_0000 | 64'($urandom_range(0, 65535));
            2: addr[11:0] = '0;
            default: ;
        endcase
        case ($urandom_range(9))
            0: len = 16'd0;
            1, 2, 3, 4: len = 16'($urandom_range(1, 600));
            5, 6, 7: len = 16'($urandom_range(1, 8192));
            8: len = 16'($urandom_range(0, 65535));
            default: len = 16'(65535 - $urandom_range(0, 100));
        endcase
        case ($urandom_range(9))
            0: mps = 11'd0;
            1: mps = 11'($urandom_range(1025, 2047));
            2: mps = 11'(1 << (3 * $urandom_range(0, 3) + 1));
            3: mps = 11'd1024;
            default: mps = 11'($urandom_range(1, 1024));
        endcase
        send_request(addr, len, mps, 5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)),
                     1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
    endtask

    task automatic test_random_traffic(input int count, input logic flavor);
        write_flavor(flavor);
        repeat (count) random_request();
        drain();
    endtask

    initial
    begin
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_zero_length();
        test_page_split();
        test_packet_size_extremes();
        test_address_wrap();
        test_flavor_flags();
        test_random_traffic(70, 1'b0);
        tx_idle_pct = 82;
        rx_idle_pct = 29;
        test_random_traffic(70, 1'b1);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_random_traffic(35, 1'b0);
        test_random_traffic(35, 1'b1);
        if (pending_items.size() != 0)
        begin
            $error("%0d expected items never arrived", pending_items.size());
            mismatch_count++;
        end
        $display("Covered %0d transfer requests in both flag flavors under three idle mixes.",
                 requests_sent);
        $display("Checked %0d Normal TRBs and %0d doorbell items; %0d mismatches.",
                 trbs_checked, doorbells_checked, mismatch_count);
        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
